// ----- rtl/rmce_pkg.sv -----
// shared types and constants of the ray march cylinder exit unit
package rmce_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS = 12;
   localparam int MAX_STEPS = 65536;
   localparam int DIR_WIDTH = 16;
   localparam int UNIT_WIDTH = FRAC_BITS + 2;
   localparam int STEP_WIDTH = 17;
   localparam int RAD_WIDTH = 31;

   localparam logic [2:0] REG_START_X = 3'd0;
   localparam logic [2:0] REG_START_Y = 3'd1;
   localparam logic [2:0] REG_START_Z = 3'd2;
   localparam logic [2:0] REG_RADIUS = 3'd3;
   localparam logic [2:0] REG_HALF_HEIGHT = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture direction and start point, begin norm sqrt
      logic sqrt_step; // one bit of the shared square root
      logic sqrt_lim;  // begin limit square root
      logic div_start; // begin one component divide
      logic div_step;  // one quotient bit
      logic div_store; // store unit component
      logic [1:0] comp;
      logic march;     // one unit step
   } rmce_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic zero_dir;
      logic sqrt_done;
      logic div_done;
      logic at_limit;
      logic is_out;
   } rmce_status_type;
endpackage

// ----- rtl/ray_march_cylinder_exit_unit.sv -----
// top level of the ray march cylinder exit unit
// usage:
//  - write start point, radius and half height on the csr port while idle;
//    a write lands at the clock edge where csr_wr_en is high
//  - each request on req_* carries one direction vector; req_tready is high
//    only while the unit is idle and no result waits
//  - the unit normalizes the direction (square root, then one divide per
//    component), finds the step limit with a second square root, then
//    marches one unit step at a time, testing for exit after each step
//  - a result on rsp_* becomes valid after the outside test that follows
//    the step that leaves the cylinder; with no exit there is no result and
//    the unit is idle again once the march reaches the step limit
//  - a zero direction gives no result and the unit is ready the next cycle
//  - one request at a time: a new request is taken only once the last one
//    is done and its result taken; the step limit is at most 65536
//  - while the receiver holds rsp_tready low the exit point stays on
//    rsp_tdata and no new request is taken
//  - reset clears the csr registers to zero, returns the controller to idle and drops a waiting result
module ray_march_cylinder_exit_unit
   import rmce_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [47:0] req_tdata,   // dir_x, dir_y, dir_z
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [95:0] rsp_tdata,   // exit_x, exit_y, exit_z
   input  logic csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);
   rmce_cmd_type cmd;
   rmce_status_type status;
   rmce_datapath u_dp (.clock, .reset, .dir_in(req_tdata), .csr_wr_en, .csr_index,
      .csr_data, .cmd, .status, .exit_out(rsp_tdata));
   rmce_ctrl u_ctrl (.clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .status, .cmd);

   // exit point held while the result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata));
endmodule

// ----- rtl/rmce_datapath.sv -----
// datapath: square root, divider, unit vector, position and outside test
module rmce_datapath
   import rmce_pkg::*;
(
   input  logic clock,
   input  logic [3*DIR_WIDTH-1:0] dir_in,
   input  logic csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data,
   input  rmce_cmd_type cmd,
   output rmce_status_type status,
   input  logic reset,
   output logic [3*32-1:0] exit_out
);
   logic signed [31:0] sx_ff, sy_ff, sz_ff;
   logic [RAD_WIDTH-1:0] rad_ff, hh_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff <= '0; sy_ff <= '0; sz_ff <= '0; rad_ff <= '0; hh_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_START_X: sx_ff <= csr_data;
            REG_START_Y: sy_ff <= csr_data;
            REG_START_Z: sz_ff <= csr_data;
            REG_RADIUS: rad_ff <= csr_data[RAD_WIDTH-1:0];
            REG_HALF_HEIGHT: hh_ff <= csr_data[RAD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   logic signed [DIR_WIDTH-1:0] d_ff [3];
   logic signed [UNIT_WIDTH-1:0] u_ff [3];
   logic signed [COORD_WIDTH-1:0] p_ff [3];
   logic [STEP_WIDTH-1:0] cnt_ff, lim_ff;

   // shared bit-serial square root over 64 bits
   logic [63:0] sv_ff, sr_ff, sb_ff;
   logic [63:0] s_sum, rr_sum, s_nxt_v, s_nxt_r;
   logic [DIR_WIDTH-1:0] ad [3];
   logic lim_mode_ff;
   logic [32:0] n_ff;
   always_comb begin
      for (int i = 0; i < 3; i++)
         ad[i] = d_ff[i][DIR_WIDTH-1] ? DIR_WIDTH'(-d_ff[i]) : d_ff[i];
   end
   logic [DIR_WIDTH-1:0] adi [3];
   always_comb begin
      for (int i = 0; i < 3; i++)
         adi[i] = dir_in[i*DIR_WIDTH+DIR_WIDTH-1] ?
            DIR_WIDTH'(-dir_in[i*DIR_WIDTH +: DIR_WIDTH]) : dir_in[i*DIR_WIDTH +: DIR_WIDTH];
      s_sum = 64'(adi[0]) * 64'(adi[0]) + 64'(adi[1]) * 64'(adi[1])
            + 64'(adi[2]) * 64'(adi[2]);
      rr_sum = 64'(rad_ff) * 64'(rad_ff) + 64'(hh_ff) * 64'(hh_ff);
      if (sv_ff >= sr_ff + sb_ff) begin
         s_nxt_v = sv_ff - (sr_ff + sb_ff);
         s_nxt_r = (sr_ff >> 1) + sb_ff;
      end else begin
         s_nxt_v = sv_ff;
         s_nxt_r = sr_ff >> 1;
      end
   end

   // restoring divider: (|d|<<28 + n/2) / n, quotient clamped to one
   localparam int DIVW = DIR_WIDTH + FRAC_BITS + 17;
   logic [DIVW-1:0] num_ff, rem_ff;
   logic [UNIT_WIDTH-1:0] q_ff, q_sat;
   logic [5:0] dcnt_ff;
   logic [DIVW:0] rem_sh;
   always_comb rem_sh = {rem_ff, num_ff[DIVW-1]};
   always_comb q_sat = (q_ff > UNIT_WIDTH'(1 << FRAC_BITS)) ? UNIT_WIDTH'(1 << FRAC_BITS) : q_ff;

   // ceiling of the limit root: a nonzero remainder means rounding up
   logic [RAD_WIDTH:0] t_up;
   always_comb begin
      t_up = (sv_ff != '0) ? sr_ff[RAD_WIDTH:0] + 1'b1 : sr_ff[RAD_WIDTH:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i] <= dir_in[i*DIR_WIDTH +: DIR_WIDTH];
            u_ff[i] <= '0;
         end
         p_ff[0] <= sx_ff; p_ff[1] <= sy_ff; p_ff[2] <= sz_ff;
         cnt_ff <= '0;
         sv_ff <= s_sum << 32; sr_ff <= '0; sb_ff <= 64'd1 << 62;
         lim_mode_ff <= 1'b0;
      end
      if (cmd.sqrt_lim) begin
         sv_ff <= rr_sum; sr_ff <= '0; sb_ff <= 64'd1 << 62;
         lim_mode_ff <= 1'b1;
      end
      if (cmd.sqrt_step) begin
         sv_ff <= s_nxt_v; sr_ff <= s_nxt_r; sb_ff <= sb_ff >> 2;
      end
      if (cmd.div_start) begin
         n_ff <= sr_ff[32:0];
         num_ff <= DIVW'({ad[cmd.comp], {(FRAC_BITS+16){1'b0}}}) + DIVW'(sr_ff[32:1]);
         rem_ff <= '0; q_ff <= '0; dcnt_ff <= 6'(DIVW);
      end
      if (cmd.div_step) begin
         if (rem_sh >= {{(DIVW-32){1'b0}}, n_ff})
            rem_ff <= DIVW'(rem_sh - {{(DIVW-32){1'b0}}, n_ff});
         else rem_ff <= DIVW'(rem_sh);
         // quotient: shift with saturation at one
         if (q_ff >= UNIT_WIDTH'(1 << FRAC_BITS))
            q_ff <= UNIT_WIDTH'(1 << FRAC_BITS);
         else q_ff <= {q_ff[UNIT_WIDTH-2:0], rem_sh >= {{(DIVW-32){1'b0}}, n_ff}};
         num_ff <= num_ff << 1;
         dcnt_ff <= dcnt_ff - 1'b1;
      end
      if (cmd.div_store)
         u_ff[cmd.comp] <= d_ff[cmd.comp][DIR_WIDTH-1] ? UNIT_WIDTH'(-q_sat) : q_sat;
      if (lim_mode_ff && status.sqrt_done && !cmd.march) begin
         if (((t_up + RAD_WIDTH'((1 << (FRAC_BITS-1)) - 1)) >> (FRAC_BITS-1)) > MAX_STEPS)
            lim_ff <= STEP_WIDTH'(MAX_STEPS);
         else
            lim_ff <= STEP_WIDTH'((t_up + RAD_WIDTH'((1 << (FRAC_BITS-1)) - 1))
                      >> (FRAC_BITS-1));
      end
      if (cmd.march) begin
         for (int i = 0; i < 3; i++)
            p_ff[i] <= p_ff[i] + COORD_WIDTH'(u_ff[i]);
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // outside test on the current position
   logic [COORD_WIDTH-1:0] ax, ay, az;
   logic [2*COORD_WIDTH:0] r2;
   always_comb begin
      ax = p_ff[0][COORD_WIDTH-1] ? COORD_WIDTH'(-p_ff[0]) : p_ff[0];
      ay = p_ff[1][COORD_WIDTH-1] ? COORD_WIDTH'(-p_ff[1]) : p_ff[1];
      az = p_ff[2][COORD_WIDTH-1] ? COORD_WIDTH'(-p_ff[2]) : p_ff[2];
      r2 = (2*COORD_WIDTH+1)'(ax) * ax + (2*COORD_WIDTH+1)'(ay) * ay;
      status.is_out = (az > COORD_WIDTH'(hh_ff)) || (ax > COORD_WIDTH'(rad_ff))
         || (ay > COORD_WIDTH'(rad_ff))
         || (r2 > (2*COORD_WIDTH+1)'(64'(rad_ff) * 64'(rad_ff)));
      status.zero_dir = (s_sum == '0);
      status.sqrt_done = (sb_ff == '0);
      status.div_done = (dcnt_ff == '0);
      status.at_limit = (cnt_ff >= lim_ff);
      exit_out = {p_ff[2][31:0], p_ff[1][31:0], p_ff[0][31:0]};
   end
endmodule

// ----- rtl/rmce_ctrl.sv -----
// controller: sequences square roots, divides and the march
module rmce_ctrl
   import rmce_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  rmce_status_type status,
   output rmce_cmd_type cmd
);
   typedef enum logic [2:0] {IDLE, NSQRT, DIV, STORE, LSQRT, LFIN, MARCH, TEST}
      state_type;
   state_type state_ff;
   logic [1:0] comp_ff;
   logic rv_ff;

   assign req_tready = (state_ff == IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;

   always_comb begin
      cmd = '0;
      cmd.comp = comp_ff;
      unique case (state_ff)
         IDLE: cmd.load = req_tvalid && req_tready;
         NSQRT: begin
            cmd.sqrt_step = !status.sqrt_done;
            cmd.div_start = status.sqrt_done;
         end
         DIV: cmd.div_step = !status.div_done;
         STORE: begin
            cmd.div_store = 1'b1;
         end
         LSQRT: cmd.sqrt_step = !status.sqrt_done;
         LFIN: cmd.sqrt_lim = 1'b1;
         MARCH: cmd.march = !status.at_limit;
         TEST: ;
         default: ;
      endcase
   end

   // one clocked block for state and the result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE; comp_ff <= '0; rv_ff <= 1'b0;
      end else begin
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         unique case (state_ff)
            IDLE: if (cmd.load && !status.zero_dir) begin
               state_ff <= NSQRT; comp_ff <= '0;
            end
            NSQRT: if (status.sqrt_done) state_ff <= DIV;
            DIV: if (status.div_done) state_ff <= STORE;
            STORE: if (comp_ff == 2'd2) state_ff <= LFIN;
               else begin
                  comp_ff <= comp_ff + 1'b1; state_ff <= NSQRT;
               end
            LFIN: state_ff <= LSQRT;
            LSQRT: if (status.sqrt_done) state_ff <= MARCH;
            TEST: if (status.is_out) begin
               rv_ff <= 1'b1; state_ff <= IDLE;
            end else state_ff <= MARCH;
            MARCH: if (status.at_limit) state_ff <= IDLE;
               else state_ff <= TEST;
            default: state_ff <= IDLE;
         endcase
      end
   end

   // result held until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid);
   // no request taken while a result waits
   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid));
   // a result only follows an outside test
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == TEST);
endmodule
